### sv/qrv_pkg.sv
package qrv_pkg;

  // Sideband that travels with each beat through the divider.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } qrv_ctl_t;

  localparam int unsigned NUM_LANES = 3;

endpackage

### sv/qrv_div_stage.sv
module qrv_div_stage #(
  parameter int RW  = 60,
  parameter int DW  = 34,
  parameter int QB  = 25,
  parameter int BIT = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qrv_pkg::qrv_ctl_t                      ctl_in,
  input  logic [DW-1:0]                          den_in,
  input  logic [qrv_pkg::NUM_LANES-1:0][RW-1:0]  rem_in,
  input  logic [qrv_pkg::NUM_LANES-1:0][QB-1:0]  quo_in,
  output qrv_pkg::qrv_ctl_t                      ctl_out,
  output logic [DW-1:0]                          den_out,
  output logic [qrv_pkg::NUM_LANES-1:0][RW-1:0]  rem_out,
  output logic [qrv_pkg::NUM_LANES-1:0][QB-1:0]  quo_out
);
  import qrv_pkg::*;

  logic [RW-1:0] den_sh;
  logic [NUM_LANES-1:0][RW:0]   diff;
  logic [NUM_LANES-1:0][RW-1:0] rem_next;
  logic [NUM_LANES-1:0][QB-1:0] quo_next;

  // one restoring step: try to take den << BIT off each remainder
  assign den_sh = RW'(den_in) << BIT;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      diff[l] = {1'b0, rem_in[l]} - {1'b0, den_sh};
      if (!diff[l][RW]) begin
        rem_next[l] = diff[l][RW-1:0];
        quo_next[l] = quo_in[l] | (QB'(1) << BIT);
      end else begin
        rem_next[l] = rem_in[l];
        quo_next[l] = quo_in[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.zero <= ctl_in.zero;
    ctl_out.neg  <= ctl_in.neg;
    den_out      <= den_in;
    rem_out      <= rem_next;
    quo_out      <= quo_next;
  end

endmodule

### sv/quaternion_rotate_vector.sv
// Quaternion vector rotation, fully pipelined.
//
// Input: a beat is taken at a rising edge with start high and busy low.
// busy is tied low: the pipeline never stalls, so a beat can be offered
// on every cycle. Each beat carries quat_x/y/z/w (signed Q3.12) and
// vec_x/y/z (signed Q11.12).
// Output: done is high for exactly one cycle per input beat, with
// rot_x/y/z = vector part of q*(v,0)*conj(q)/|q|^2, rounded to nearest
// (ties away from zero) and clamped; saturated flags a clamp and
// zero_quaternion flags |q|^2 == 0 (rotation then reads as zero).
// Throughput is one beat per cycle. The restoring divider takes one
// quotient bit per stage over VEC_WIDTH + 1 stages, after six stages of
// input capture, products, matrix build, products, sums and divider setup,
// and done is registered after the last divider stage.
// Results are in order and never held off; the receiver must take done
// beats as they come. Reset clears all valid bits; nothing in flight
// survives it.
module quaternion_rotate_vector #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [VEC_WIDTH-1:0]  vec_x,
  input  logic signed [VEC_WIDTH-1:0]  vec_y,
  input  logic signed [VEC_WIDTH-1:0]  vec_z,
  output logic                        done,
  output logic signed [VEC_WIDTH-1:0]  rot_x,
  output logic signed [VEC_WIDTH-1:0]  rot_y,
  output logic signed [VEC_WIDTH-1:0]  rot_z,
  output logic                        saturated,
  output logic                        zero_quaternion
);
  import qrv_pkg::*;

  localparam int PW  = 2 * QUAT_WIDTH;          // component product
  localparam int NW  = 2 * QUAT_WIDTH + 1;      // |q|^2, unsigned
  localparam int MW  = 2 * QUAT_WIDTH + 2;      // scaled matrix entry
  localparam int XW  = MW + VEC_WIDTH;          // entry times vector
  localparam int AW  = 2 * QUAT_WIDTH + VEC_WIDTH + 3; // row sum
  localparam int RW  = AW + 1;                  // divider remainder
  localparam int DW  = NW + 1;                  // divisor 2n
  localparam int QB  = VEC_WIDTH + 1;           // quotient bits
  localparam int LAT = VEC_WIDTH + 8;

  assign busy = 1'b0;

  // stage 1: input capture
  logic v1;
  logic signed [QUAT_WIDTH-1:0] q1 [4];
  logic signed [VEC_WIDTH-1:0]  vec1 [NUM_LANES];

  // stage 2: ten component products
  logic v2;
  logic signed [PW-1:0] xx2, yy2, zz2, ww2, xy2, xz2, yz2, wx2, wy2, wz2;
  logic signed [VEC_WIDTH-1:0] vec2 [NUM_LANES];

  // stage 3: rotation matrix scaled by n, and n
  logic v3;
  logic signed [MW-1:0] m3 [9];
  logic [NW-1:0] n3;
  logic signed [VEC_WIDTH-1:0] vec3 [NUM_LANES];

  // stage 4: matrix times vector products
  logic v4;
  logic signed [XW-1:0] p4 [9];
  logic [NW-1:0] n4;

  // stage 5: row sums
  logic v5;
  logic signed [AW-1:0] s5 [NUM_LANES];
  logic [NW-1:0] n5;

  // divider chain
  qrv_ctl_t ctl [QB+1];
  logic [DW-1:0] den [QB+1];
  logic [NUM_LANES-1:0][RW-1:0] rem [QB+1];
  logic [NUM_LANES-1:0][QB-1:0] quo [QB+1];

  logic [AW-1:0] mag [NUM_LANES];
  qrv_ctl_t ctl_next;

  localparam logic [QB-1:0] LIM = QB'(1) << (VEC_WIDTH - 1);
  logic signed [VEC_WIDTH-1:0] res [NUM_LANES];
  logic [NUM_LANES-1:0] sat_l;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      done <= ctl[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    q1[0]   <= quat_x;
    q1[1]   <= quat_y;
    q1[2]   <= quat_z;
    q1[3]   <= quat_w;
    vec1[0] <= vec_x;
    vec1[1] <= vec_y;
    vec1[2] <= vec_z;

    xx2 <= PW'(q1[0]) * PW'(q1[0]);
    yy2 <= PW'(q1[1]) * PW'(q1[1]);
    zz2 <= PW'(q1[2]) * PW'(q1[2]);
    ww2 <= PW'(q1[3]) * PW'(q1[3]);
    xy2 <= PW'(q1[0]) * PW'(q1[1]);
    xz2 <= PW'(q1[0]) * PW'(q1[2]);
    yz2 <= PW'(q1[1]) * PW'(q1[2]);
    wx2 <= PW'(q1[3]) * PW'(q1[0]);
    wy2 <= PW'(q1[3]) * PW'(q1[1]);
    wz2 <= PW'(q1[3]) * PW'(q1[2]);
    vec2 <= vec1;

    // squares are never negative, so the sum is taken unsigned
    n3 <= NW'(unsigned'(xx2)) + NW'(unsigned'(yy2))
        + NW'(unsigned'(zz2)) + NW'(unsigned'(ww2));
    m3[0] <= MW'(ww2) + MW'(xx2) - MW'(yy2) - MW'(zz2);
    m3[1] <= (MW'(xy2) - MW'(wz2)) <<< 1;
    m3[2] <= (MW'(xz2) + MW'(wy2)) <<< 1;
    m3[3] <= (MW'(xy2) + MW'(wz2)) <<< 1;
    m3[4] <= MW'(ww2) - MW'(xx2) + MW'(yy2) - MW'(zz2);
    m3[5] <= (MW'(yz2) - MW'(wx2)) <<< 1;
    m3[6] <= (MW'(xz2) - MW'(wy2)) <<< 1;
    m3[7] <= (MW'(yz2) + MW'(wx2)) <<< 1;
    m3[8] <= MW'(ww2) - MW'(xx2) - MW'(yy2) + MW'(zz2);
    vec3 <= vec2;

    for (int r = 0; r < NUM_LANES; r++) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        p4[r*3+c] <= XW'(m3[r*3+c]) * XW'(vec3[c]);
      end
    end
    n4 <= n3;

    for (int r = 0; r < NUM_LANES; r++) begin
      s5[r] <= AW'(p4[r*3]) + AW'(p4[r*3+1]) + AW'(p4[r*3+2]);
    end
    n5 <= n4;
  end

  // divider setup: numerator 2|N| + n, divisor 2n gives rounded |N|/n
  always_comb begin
    ctl_next.valid = v5;
    ctl_next.zero  = (n5 == '0);
    for (int l = 0; l < NUM_LANES; l++) begin
      ctl_next.neg[l] = s5[l][AW-1];
      mag[l] = s5[l][AW-1] ? AW'(-s5[l]) : AW'(s5[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= ctl_next.valid;
    end
    ctl[0].zero <= ctl_next.zero;
    ctl[0].neg  <= ctl_next.neg;
    den[0]      <= {n5, 1'b0};
    for (int l = 0; l < NUM_LANES; l++) begin
      rem[0][l] <= {mag[l], 1'b0} + RW'(n5);
      quo[0][l] <= '0;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    qrv_div_stage #(
      .RW (RW),
      .DW (DW),
      .QB (QB),
      .BIT(QB - 1 - s)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl[s]),
      .den_in (den[s]),
      .rem_in (rem[s]),
      .quo_in (quo[s]),
      .ctl_out(ctl[s+1]),
      .den_out(den[s+1]),
      .rem_out(rem[s+1]),
      .quo_out(quo[s+1])
    );
  end

  // sign, clamp and zero-quaternion override
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (ctl[QB].neg[l]) begin
        sat_l[l] = quo[QB][l] > LIM;
        res[l]   = sat_l[l] ? VEC_WIDTH'(-(LIM)) : VEC_WIDTH'(-quo[QB][l]);
      end else begin
        sat_l[l] = quo[QB][l] >= LIM;
        res[l]   = sat_l[l] ? VEC_WIDTH'(LIM - QB'(1)) : VEC_WIDTH'(quo[QB][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[QB].zero) begin
      rot_x           <= '0;
      rot_y           <= '0;
      rot_z           <= '0;
      saturated       <= 1'b0;
      zero_quaternion <= 1'b1;
    end else begin
      rot_x           <= res[0];
      rot_y           <= res[1];
      rot_z           <= res[2];
      saturated       <= |sat_l;
      zero_quaternion <= 1'b0;
    end
  end

  // every accepted start beat is followed by a done beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result beat missing at fixed latency");

  // a done beat never appears without a matching accepted start beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without matching start");

  // zero quaternion forces a zero vector and no clamp
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && zero_quaternion) |-> (!saturated && rot_x == '0 && rot_y == '0 && rot_z == '0))
    else $error("zero quaternion result not cleared");

endmodule

### sim/quaternion_rotate_vector_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the quaternion vector rotation pipeline.
// A predictor rebuilds the rotation matrix scaled by |q|^2, divides with
// round-half-away-from-zero and clamps to 24 bits. A monitor queues one
// expected beat per accepted start beat and compares each done beat with
// the oldest one in the queue.
module quaternion_rotate_vector_tb;
  import qrv_pkg::*;

  localparam int QW      = 16;
  localparam int VW      = 24;
  localparam int LATENCY = VW + 8;

  typedef struct {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 sat;
    logic                 zq;
  } rot_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [VW-1:0] vec_x, vec_y, vec_z;
  logic                 done;
  logic signed [VW-1:0] rot_x, rot_y, rot_z;
  logic                 saturated;
  logic                 zero_quaternion;

  rot_beat_t pending_rot[$];
  int        mismatches;
  int        beats_sent;
  int        beats_checked;
  int        sat_seen;
  int        zero_seen;
  bit        no_idle;   // set for the stretch with no gaps

  quaternion_rotate_vector uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .saturated(saturated), .zero_quaternion(zero_quaternion)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Expected rotation: matrix entries scaled by n = |q|^2, so each
  // component is N / n, rounded as floor((2|N| + n) / 2n).
  function automatic rot_beat_t rotate_predict(
      input logic signed [QW-1:0] qx, qy, qz, qw,
      input logic signed [VW-1:0] vx, vy, vz);
    logic signed [127:0] x, y, z, w, a, b, c, n, acc;
    logic signed [127:0] m[3][3];
    logic        [127:0] mag, quo;
    logic signed [VW-1:0] res[3];
    logic                 neg;
    rot_beat_t r;
    x = qx; y = qy; z = qz; w = qw;
    a = vx; b = vy; c = vz;
    n = x*x + y*y + z*z + w*w;
    r.sat = 1'b0;
    r.zq  = 1'b0;
    if (n == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.zq = 1'b1;
      return r;
    end
    m[0][0] = w*w + x*x - y*y - z*z;
    m[0][1] = 2*(x*y - w*z);
    m[0][2] = 2*(x*z + w*y);
    m[1][0] = 2*(x*y + w*z);
    m[1][1] = w*w - x*x + y*y - z*z;
    m[1][2] = 2*(y*z - w*x);
    m[2][0] = 2*(x*z - w*y);
    m[2][1] = 2*(y*z + w*x);
    m[2][2] = w*w - x*x - y*y + z*z;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0]*a + m[i][1]*b + m[i][2]*c;
      neg = acc < 0;
      mag = neg ? -acc : acc;
      quo = (2*mag + n) / (2*n);
      if (neg) begin
        if (quo > (128'd1 << (VW-1))) begin
          r.sat = 1'b1;
          res[i] = {1'b1, {(VW-1){1'b0}}};
        end else begin
          res[i] = -quo[VW-1:0];
        end
      end else begin
        if (quo > ((128'd1 << (VW-1)) - 1)) begin
          r.sat = 1'b1;
          res[i] = {1'b0, {(VW-1){1'b1}}};
        end else begin
          res[i] = quo[VW-1:0];
        end
      end
    end
    r.x = res[0]; r.y = res[1]; r.z = res[2];
    return r;
  endfunction

  // Monitor: sampled at the edge, so values are the ones held before it.
  // The start beat is queued first; latency keeps it behind older ones.
  always @(posedge clk) begin
    rot_beat_t e;
    if (!rst && start && !busy)
      pending_rot.push_back(rotate_predict(quat_x, quat_y, quat_z, quat_w,
                                           vec_x, vec_y, vec_z));
    if (!rst && done) begin
      if (pending_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: done beat with nothing expected: %0d %0d %0d",
                   rot_x, rot_y, rot_z);
      end else begin
        e = pending_rot.pop_front();
        beats_checked++;
        if (e.sat) sat_seen++;
        if (e.zq) zero_seen++;
        if (rot_x !== e.x || rot_y !== e.y || rot_z !== e.z ||
            saturated !== e.sat || zero_quaternion !== e.zq) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: beat %0d exp %0d %0d %0d sat=%b zq=%b, got %0d %0d %0d sat=%b zq=%b",
                     beats_checked, e.x, e.y, e.z, e.sat, e.zq,
                     rot_x, rot_y, rot_z, saturated, zero_quaternion);
        end
      end
    end
  end

  // Drive one beat, after a random idle gap unless no_idle is set; hold start until the edge that takes it.
  task automatic send_rotation(input logic signed [QW-1:0] qx, qy, qz, qw,
                               input logic signed [VW-1:0] vx, vy, vz);
    int gap;
    if (!no_idle && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    vec_x  <= vx; vec_y  <= vy; vec_z  <= vz;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic signed [QW-1:0] any_quat();
    return QW'($urandom);
  endfunction

  function automatic logic signed [VW-1:0] any_vec();
    return VW'($urandom);
  endfunction

  // Extremes, identity, zero quaternion, clamps both ways.
  task automatic test_directed();
    localparam logic signed [QW-1:0] QMAX = 16'sh7FFF, QMIN = 16'sh8000;
    localparam logic signed [VW-1:0] VMAX = 24'sh7FFFFF, VMIN = 24'sh800000;
    send_rotation(0, 0, 0, 4096, 4096, -8192, 12288);      // identity
    send_rotation(0, 0, 0, 0, VMAX, VMIN, 1);               // zero quaternion
    send_rotation(0, 0, 0, 0, 0, 0, 0);
    send_rotation(4096, 0, 0, 0, VMAX, VMIN, VMAX);         // 180 deg about x
    send_rotation(0, 4096, 0, 0, VMIN, VMIN, VMIN);
    send_rotation(0, 0, 2896, 2896, VMAX, 0, 0);            // 90 deg about z
    send_rotation(QMAX, QMAX, QMAX, QMAX, VMAX, VMAX, VMAX); // permutes axes, no clamp
    send_rotation(QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN); // permutes axes, no clamp
    send_rotation(QMIN, 0, 0, 0, VMAX, VMAX, VMAX);
    send_rotation(0, QMAX, 0, QMIN, VMIN, VMAX, VMIN);
    send_rotation(1, 1, 1, 1, 1, -1, 1);
    send_rotation(1, 0, 0, 1, 3, 5, 7);
    send_rotation(3, 1, 1, 1, -5, 7, -9);
    send_rotation(-1, -1, -1, -1, VMAX, VMIN, 0);
    send_rotation(2, 1, 0, 0, VMAX, VMAX, VMIN);
    send_rotation(QMAX, 1, 0, 0, 1, VMAX, VMIN);
    send_rotation(-1, 0, 0, 0, -1, -1, -1);
  endtask

  // Small quaternions: |q|^2 tiny, so rounding and halves show up often.
  task automatic test_rounding(input int count);
    for (int i = 0; i < count; i++)
      send_rotation(QW'($urandom_range(0, 6) - 3), QW'($urandom_range(0, 6) - 3),
                    QW'($urandom_range(0, 6) - 3), QW'($urandom_range(0, 6) - 3),
                    any_vec(), any_vec(), any_vec());
  endtask

  // Quaternions with components in [-1, 1] and random vectors; some full random and zeros.
  task automatic test_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_rotation(QW'($urandom_range(0, 8192) - 4096),
                      QW'($urandom_range(0, 8192) - 4096),
                      QW'($urandom_range(0, 8192) - 4096),
                      QW'($urandom_range(0, 8192) - 4096),
                      any_vec(), any_vec(), any_vec());
      else if (pick < 95)
        send_rotation(any_quat(), any_quat(), any_quat(), any_quat(),
                      any_vec(), any_vec(), any_vec());
      else
        send_rotation(0, 0, 0, 0, any_vec(), any_vec(), any_vec());
    end
  endtask

  // Back-to-back beats, no gaps on the input side.
  task automatic test_streaming(input int count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    vec_x  = '0; vec_y  = '0; vec_z  = '0;
    mismatches = 0; beats_sent = 0; beats_checked = 0;
    sat_seen = 0; zero_seen = 0; no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_rounding(250);
    test_random(550);
    test_streaming(300);
    test_random(100);

    start <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d beats, checked %0d results (%0d clamped, %0d zero quaternion).",
             beats_sent, beats_checked, sat_seen, zero_seen);
    if (mismatches == 0 && pending_rot.size() == 0) begin
      $display("quaternion_rotate_vector verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("quaternion_rotate_vector verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("quaternion_rotate_vector verification failed");
    $finish;
  end

endmodule
